[rtl/wsrs_pkg.sv]
// Shared types and constants for the wheel speed ratio saturator.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps

package wsrs_pkg;

  // Configuration registers are 15 bits wide, in Q7.8 units.
  localparam int CFG_WIDTH       = 15;
  localparam int CFG_INDEX_WIDTH = 2;

  localparam logic [CFG_INDEX_WIDTH-1:0] REG_WHEEL_SPEED_MAX = 2'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_STEER_HEADROOM  = 2'd1;

  localparam logic [CFG_WIDTH-1:0] WHEEL_SPEED_MAX_RESET = 15'h7fff;
  localparam logic [CFG_WIDTH-1:0] STEER_HEADROOM_RESET  = 15'h0000;

  // The scaled magnitude never exceeds the ceiling, so it fits in CFG_WIDTH bits.
  localparam int QUOT_WIDTH = CFG_WIDTH;

  // Depth of the queue between the classifier and the scaling pipeline.
  localparam int QUEUE_DEPTH = 4;

  typedef struct packed {
    logic neg_l;
    logic neg_r;
    logic scale;
  } wsrs_flags_t;

endpackage

[rtl/wheel_speed_ratio_saturator.sv]
// Top level of the wheel speed ratio saturator: front end with queue and the
// multiply and divide back end. Uses wsrs_pkg, wsrs_front and wsrs_back.
//
//   Port group     Direction  Handshake                      Payload
//   config         in         cfg_write                      cfg_index, cfg_data
//   speed request  in         speed_valid / speed_ready      left_speed, right_speed
//   limited speed  out        limited_valid / limited_ready  left_limited, right_limited,
//                                                            was_scaled
//
// One item per cycle sustained while results are taken. From acceptance an item passes
// the queue, the multiplier stage, 15 divider stages (one quotient bit each) and the result
// register; the divider stages make up most of that path.
// Reset clears the queue, the pipeline valid bits and loads the register reset values.
// A stalled result freezes the back end; the four-entry queue keeps taking items until full.
`timescale 1ns / 1ps

module wheel_speed_ratio_saturator import wsrs_pkg::*; #(
  parameter int SPEED_WIDTH = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_write,
  input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [CFG_WIDTH-1:0]       cfg_data,
  input  logic                       speed_valid,
  output logic                       speed_ready,
  input  logic [SPEED_WIDTH-1:0]     left_speed,
  input  logic [SPEED_WIDTH-1:0]     right_speed,
  output logic                       limited_valid,
  input  logic                       limited_ready,
  output logic [SPEED_WIDTH-1:0]     left_limited,
  output logic [SPEED_WIDTH-1:0]     right_limited,
  output logic                       was_scaled
);

  logic                   q_valid, q_ready;
  logic [SPEED_WIDTH-1:0] q_mag_l, q_mag_r, q_peak;
  logic [CFG_WIDTH-1:0]   q_ceiling;
  wsrs_flags_t            q_flags;

  wsrs_front #(
    .SPEED_WIDTH (SPEED_WIDTH)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .speed_valid (speed_valid),
    .speed_ready (speed_ready),
    .left_speed  (left_speed),
    .right_speed (right_speed),
    .q_valid     (q_valid),
    .q_ready     (q_ready),
    .q_mag_l     (q_mag_l),
    .q_mag_r     (q_mag_r),
    .q_peak      (q_peak),
    .q_ceiling   (q_ceiling),
    .q_flags     (q_flags)
  );

  wsrs_back #(
    .SPEED_WIDTH (SPEED_WIDTH)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_valid),
    .q_ready       (q_ready),
    .q_mag_l       (q_mag_l),
    .q_mag_r       (q_mag_r),
    .q_peak        (q_peak),
    .q_ceiling     (q_ceiling),
    .q_flags       (q_flags),
    .limited_valid (limited_valid),
    .limited_ready (limited_ready),
    .left_limited  (left_limited),
    .right_limited (right_limited),
    .was_scaled    (was_scaled)
  );

endmodule

[rtl/wsrs_front.sv]
// Front end: configuration registers, magnitude split, ceiling and peak
// classification, and a short queue toward the scaling pipeline. Uses wsrs_pkg.
`timescale 1ns / 1ps

module wsrs_front import wsrs_pkg::*; #(
  parameter int SPEED_WIDTH = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_write,
  input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [CFG_WIDTH-1:0]       cfg_data,
  input  logic                       speed_valid,
  output logic                       speed_ready,
  input  logic [SPEED_WIDTH-1:0]     left_speed,
  input  logic [SPEED_WIDTH-1:0]     right_speed,
  output logic                       q_valid,
  input  logic                       q_ready,
  output logic [SPEED_WIDTH-1:0]     q_mag_l,
  output logic [SPEED_WIDTH-1:0]     q_mag_r,
  output logic [SPEED_WIDTH-1:0]     q_peak,
  output logic [CFG_WIDTH-1:0]       q_ceiling,
  output wsrs_flags_t                q_flags
);

  localparam int CMP_WIDTH = (SPEED_WIDTH > CFG_WIDTH) ? SPEED_WIDTH : CFG_WIDTH;
  localparam int PTR_WIDTH = $clog2(QUEUE_DEPTH);
  localparam int CNT_WIDTH = $clog2(QUEUE_DEPTH + 1);

  logic [CFG_WIDTH-1:0] wheel_speed_max;
  logic [CFG_WIDTH-1:0] steer_headroom;

  always_ff @(posedge clk) begin
    if (rst) begin
      wheel_speed_max <= WHEEL_SPEED_MAX_RESET;
      steer_headroom  <= STEER_HEADROOM_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_WHEEL_SPEED_MAX: wheel_speed_max <= cfg_data;
        REG_STEER_HEADROOM:  steer_headroom  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Classification of the incoming item.
  logic [SPEED_WIDTH-1:0] mag_l, mag_r, peak;
  logic [CFG_WIDTH-1:0]   ceiling;
  wsrs_flags_t            flags;

  always_comb begin
    flags.neg_l = left_speed[SPEED_WIDTH-1];
    flags.neg_r = right_speed[SPEED_WIDTH-1];
    // The most negative input yields 2^(SPEED_WIDTH-1), still exact as unsigned.
    mag_l   = flags.neg_l ? (~left_speed + 1'b1)  : left_speed;
    mag_r   = flags.neg_r ? (~right_speed + 1'b1) : right_speed;
    peak    = (mag_l > mag_r) ? mag_l : mag_r;
    ceiling = (wheel_speed_max > steer_headroom) ? (wheel_speed_max - steer_headroom) : '0;
    flags.scale = CMP_WIDTH'(peak) > CMP_WIDTH'(ceiling);
  end

  // Queue storage.
  logic [SPEED_WIDTH-1:0] mem_mag_l   [QUEUE_DEPTH];
  logic [SPEED_WIDTH-1:0] mem_mag_r   [QUEUE_DEPTH];
  logic [SPEED_WIDTH-1:0] mem_peak    [QUEUE_DEPTH];
  logic [CFG_WIDTH-1:0]   mem_ceiling [QUEUE_DEPTH];
  wsrs_flags_t            mem_flags   [QUEUE_DEPTH];

  logic [PTR_WIDTH-1:0] wr_ptr, rd_ptr;
  logic [CNT_WIDTH-1:0] count;
  logic                 push, pop;

  assign speed_ready = (count != CNT_WIDTH'(QUEUE_DEPTH));
  assign push        = speed_valid && speed_ready;
  assign q_valid     = (count != '0);
  assign pop         = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_mag_l[wr_ptr]   <= mag_l;
      mem_mag_r[wr_ptr]   <= mag_r;
      mem_peak[wr_ptr]    <= peak;
      mem_ceiling[wr_ptr] <= ceiling;
      mem_flags[wr_ptr]   <= flags;
    end
  end

  assign q_mag_l   = mem_mag_l[rd_ptr];
  assign q_mag_r   = mem_mag_r[rd_ptr];
  assign q_peak    = mem_peak[rd_ptr];
  assign q_ceiling = mem_ceiling[rd_ptr];
  assign q_flags   = mem_flags[rd_ptr];

endmodule

[rtl/wsrs_back.sv]
// Back end: multiply by the ceiling, a restoring divider with one quotient bit
// per stage for both wheels, and the result register. Uses wsrs_pkg.
`timescale 1ns / 1ps

module wsrs_back import wsrs_pkg::*; #(
  parameter int SPEED_WIDTH = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   q_valid,
  output logic                   q_ready,
  input  logic [SPEED_WIDTH-1:0] q_mag_l,
  input  logic [SPEED_WIDTH-1:0] q_mag_r,
  input  logic [SPEED_WIDTH-1:0] q_peak,
  input  logic [CFG_WIDTH-1:0]   q_ceiling,
  input  wsrs_flags_t            q_flags,
  output logic                   limited_valid,
  input  logic                   limited_ready,
  output logic [SPEED_WIDTH-1:0] left_limited,
  output logic [SPEED_WIDTH-1:0] right_limited,
  output logic                   was_scaled
);

  localparam int W     = SPEED_WIDTH;
  localparam int PW    = SPEED_WIDTH + CFG_WIDTH;
  localparam int NDIV  = QUOT_WIDTH;

  // The whole pipeline moves when the result register is free or being emptied.
  logic adv;
  assign adv     = !limited_valid || limited_ready;
  assign q_ready = adv;

  logic [NDIV:0]         vld;
  logic [W-1:0]          rem_l  [NDIV+1];
  logic [W-1:0]          rem_r  [NDIV+1];
  logic [QUOT_WIDTH-1:0] lq_l   [NDIV+1];
  logic [QUOT_WIDTH-1:0] lq_r   [NDIV+1];
  logic [W-1:0]          peak_s [NDIV+1];
  logic [W-1:0]          mag_l_s[NDIV+1];
  logic [W-1:0]          mag_r_s[NDIV+1];
  wsrs_flags_t           flg_s  [NDIV+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NDIV-1:0], q_valid};
    end
  end

  // Stage zero: products of magnitude and ceiling, split into the starting
  // partial remainder and the dividend bits still to be shifted in.
  logic [PW-1:0] prod_l, prod_r;
  assign prod_l = PW'(q_mag_l) * PW'(q_ceiling);
  assign prod_r = PW'(q_mag_r) * PW'(q_ceiling);

  always_ff @(posedge clk) begin
    if (adv) begin
      rem_l[0]   <= prod_l[PW-1:QUOT_WIDTH];
      rem_r[0]   <= prod_r[PW-1:QUOT_WIDTH];
      lq_l[0]    <= prod_l[QUOT_WIDTH-1:0];
      lq_r[0]    <= prod_r[QUOT_WIDTH-1:0];
      peak_s[0]  <= q_peak;
      mag_l_s[0] <= q_mag_l;
      mag_r_s[0] <= q_mag_r;
      flg_s[0]   <= q_flags;
    end
  end

  // Each stage shifts in one dividend bit and retires one quotient bit.
  // For scaled items the partial remainder stays below the peak throughout.
  for (genvar k = 1; k <= NDIV; k++) begin : g_div
    logic [W:0] tl, tr, dl, dr;
    logic       gel, ger;

    always_comb begin
      tl  = {rem_l[k-1], lq_l[k-1][QUOT_WIDTH-1]};
      tr  = {rem_r[k-1], lq_r[k-1][QUOT_WIDTH-1]};
      gel = tl >= {1'b0, peak_s[k-1]};
      ger = tr >= {1'b0, peak_s[k-1]};
      dl  = tl - {1'b0, peak_s[k-1]};
      dr  = tr - {1'b0, peak_s[k-1]};
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rem_l[k]   <= gel ? dl[W-1:0] : tl[W-1:0];
        rem_r[k]   <= ger ? dr[W-1:0] : tr[W-1:0];
        lq_l[k]    <= {lq_l[k-1][QUOT_WIDTH-2:0], gel};
        lq_r[k]    <= {lq_r[k-1][QUOT_WIDTH-2:0], ger};
        peak_s[k]  <= peak_s[k-1];
        mag_l_s[k] <= mag_l_s[k-1];
        mag_r_s[k] <= mag_r_s[k-1];
        flg_s[k]   <= flg_s[k-1];
      end
    end
  end

  // Pick the scaled or original magnitude and restore the sign.
  logic [W-1:0] val_l, val_r, fld_l, fld_r;

  always_comb begin
    val_l = flg_s[NDIV].scale ? W'(lq_l[NDIV]) : mag_l_s[NDIV];
    val_r = flg_s[NDIV].scale ? W'(lq_r[NDIV]) : mag_r_s[NDIV];
    fld_l = flg_s[NDIV].neg_l ? (~val_l + 1'b1) : val_l;
    fld_r = flg_s[NDIV].neg_r ? (~val_r + 1'b1) : val_r;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      limited_valid <= 1'b0;
    end else if (adv) begin
      limited_valid <= vld[NDIV];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      left_limited  <= fld_l;
      right_limited <= fld_r;
      was_scaled    <= flg_s[NDIV].scale;
    end
  end

endmodule
